// ----- design/nppe_pkg.sv -----
package nppe_pkg;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_COLOR     = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS_DELTA = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DARKEN_PHASE     = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WATER_BANK       = 4'd3;

  localparam logic [3:0] OP_OVERWRITE  = 4'd0;
  localparam logic [3:0] OP_BLEND      = 4'd1;
  localparam logic [3:0] OP_RECOLOR    = 4'd2;
  localparam logic [3:0] OP_BRIGHTNESS = 4'd3;
  localparam logic [3:0] OP_DARKEN     = 4'd4;
  localparam logic [3:0] OP_LAVA       = 4'd5;
  localparam logic [3:0] OP_WATER      = 4'd6;
  localparam logic [3:0] OP_BLUR       = 4'd7;
  localparam logic [3:0] OP_ICED_BLUR  = 4'd8;

  localparam logic [3:0] LAVA_BANK = 4'h7;
  localparam logic [3:0] ICE_BANK  = 4'h8;
  localparam logic [3:0] MAX_LEVEL = 4'hf;

  typedef struct packed {
    logic [3:0]         filter_color;
    logic signed [7:0]  brightness_delta;
    logic [15:0]        darken_phase;
    logic [3:0]         water_bank;
  } cfg_t;

  typedef struct packed {
    logic [3:0]         op;
    logic [7:0]         src;
    logic [7:0]         dst;
    logic [3:0]         half_sd;
    logic [3:0]         lava_q;
    logic [3:0]         water_half;
    logic signed [8:0]  bright_t;
    logic [3:0]         ripple;
  } prep_t;

  typedef struct packed {
    logic [3:0] op;
    logic [7:0] src;
    logic [7:0] dst;
    logic [3:0] half_sd;
    logic [3:0] lava_q;
    logic [3:0] water_half;
    logic [3:0] bright_lo;
    logic [3:0] darken_lo;
  } fx_t;

endpackage

// ----- design/nppe_cfg.sv -----
module nppe_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [nppe_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [nppe_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output nppe_pkg::cfg_t                      cfg_r
);

  nppe_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        nppe_pkg::REG_FILTER_COLOR:     cfg_nxt.filter_color     = cfg_wdata[3:0];
        nppe_pkg::REG_BRIGHTNESS_DELTA: cfg_nxt.brightness_delta = $signed(cfg_wdata[7:0]);
        nppe_pkg::REG_DARKEN_PHASE:     cfg_nxt.darken_phase     = cfg_wdata[15:0];
        nppe_pkg::REG_WATER_BANK:       cfg_nxt.water_bank       = cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- design/nppe_prep.sv -----
module nppe_prep (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  logic                 valid_in,
  input  logic [3:0]           operation,
  input  logic [7:0]           src_pixel,
  input  logic [7:0]           dst_pixel,
  input  logic [7:0]           neighbor_a,
  input  logic [7:0]           neighbor_b,
  input  logic                 edge_flag,
  input  logic [8:0]           column,
  input  logic [7:0]           row,
  input  nppe_pkg::cfg_t       cfg,
  output logic                 valid_r,
  output nppe_pkg::prep_t      data_r
);

  nppe_pkg::prep_t data_nxt;
  logic [5:0] diff;
  logic [3:0] b_term;
  logic [4:0] sum_sd;
  logic [4:0] sum_sa;
  logic [5:0] sum_lava;

  always_comb begin
    // only bits [5:2] of the ripple difference reach the nibble sum
    diff     = column[5:0] - cfg.darken_phase[5:0] - row[5:0];
    b_term   = edge_flag ? 4'd0 : neighbor_b[3:0];
    sum_sd   = {1'b0, src_pixel[3:0]} + {1'b0, dst_pixel[3:0]};
    sum_sa   = {1'b0, src_pixel[3:0]} + {1'b0, neighbor_a[3:0]};
    sum_lava = {2'b0, src_pixel[3:0]} + {2'b0, neighbor_a[3:0]} + {2'b0, b_term};

    data_nxt.op         = operation;
    data_nxt.src        = src_pixel;
    data_nxt.dst        = dst_pixel;
    data_nxt.half_sd    = sum_sd[4:1];
    data_nxt.lava_q     = sum_lava[5:2];
    data_nxt.water_half = sum_sa[4:1];
    data_nxt.bright_t   = $signed({5'b0, dst_pixel[3:0]})
                          + $signed({cfg.brightness_delta[7], cfg.brightness_delta});
    data_nxt.ripple     = diff[5:2] + neighbor_a[3:0] + b_term;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- design/nppe_fx.sv -----
module nppe_fx (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  logic                 valid_in,
  input  nppe_pkg::prep_t      data_in,
  output logic                 valid_r,
  output nppe_pkg::fx_t        data_r
);

  nppe_pkg::fx_t data_nxt;
  logic [3:0] lvl;
  logic [7:0] dark_acc;

  always_comb begin
    lvl      = data_in.dst[3:0];
    // 15*L(d) + r, at most 240
    dark_acc = {lvl, 4'b0} - {4'b0, lvl} + {4'b0, data_in.ripple};

    data_nxt.op         = data_in.op;
    data_nxt.src        = data_in.src;
    data_nxt.dst        = data_in.dst;
    data_nxt.half_sd    = data_in.half_sd;
    data_nxt.lava_q     = data_in.lava_q;
    data_nxt.water_half = data_in.water_half;
    data_nxt.darken_lo  = dark_acc[7:4];
    if (data_in.bright_t[8] || (data_in.bright_t[7:5] != 3'b0)) begin
      data_nxt.bright_lo = 4'd0;
    end else if (data_in.bright_t[4]) begin
      data_nxt.bright_lo = nppe_pkg::MAX_LEVEL;
    end else begin
      data_nxt.bright_lo = data_in.bright_t[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- design/nppe_sel.sv -----
module nppe_sel (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  logic                 valid_in,
  input  nppe_pkg::fx_t        data_in,
  input  nppe_pkg::cfg_t       cfg,
  output logic                 valid_r,
  output logic [7:0]           pixel_r
);

  logic [7:0] pixel_nxt;
  logic       src_nz;

  always_comb begin
    src_nz = (data_in.src != 8'd0);
    case (data_in.op)
      nppe_pkg::OP_OVERWRITE:  pixel_nxt = src_nz ? data_in.src : data_in.dst;
      nppe_pkg::OP_BLEND:      pixel_nxt = src_nz ? {data_in.src[7:4], data_in.half_sd}
                                                  : data_in.dst;
      nppe_pkg::OP_RECOLOR:    pixel_nxt = {cfg.filter_color, data_in.dst[3:0]};
      nppe_pkg::OP_BRIGHTNESS: pixel_nxt = {data_in.dst[7:4], data_in.bright_lo};
      nppe_pkg::OP_DARKEN:     pixel_nxt = {data_in.dst[7:4], data_in.darken_lo};
      nppe_pkg::OP_LAVA:       pixel_nxt = {nppe_pkg::LAVA_BANK, data_in.lava_q};
      nppe_pkg::OP_WATER:      pixel_nxt = (data_in.src[5:4] != 2'b0)
                                           ? {cfg.water_bank, data_in.water_half}
                                           : data_in.src;
      nppe_pkg::OP_BLUR:       pixel_nxt = {data_in.src[7:4], data_in.half_sd};
      nppe_pkg::OP_ICED_BLUR:  pixel_nxt = {nppe_pkg::ICE_BANK, data_in.half_sd};
      default:                 pixel_nxt = data_in.dst;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel_r <= pixel_nxt;
    end
  end

endmodule

// ----- design/nibble_palette_pixel_effects.sv -----
// Pixel effect unit: one 8-bit pixel word in, one 8-bit pixel word out.
// Input channel (in_*): operation code, source/destination pixels, two
// neighbor pixels, edge flag and the column/row position, moved with
// in_valid/in_stall. A word is taken on a clock edge with in_valid high and
// in_stall low.
// Output channel (out_*): out_result_pixel with out_valid/out_stall.
// Config port (cfg_*): write-only; index 0 filter color, 1 brightness delta,
// 2 darken phase, 3 water bank; other indexes are dropped. Write only while
// no word is in flight.
// The pipeline has three registers (prepare, effect, select/output register);
// throughput is one word per cycle while out_stall does not hold the output.
// Reset clears all config registers to zero and empties the pipeline.
// When out_stall holds off a finished word, empty stages still fill, so up to
// three words are held before in_stall rises; nothing is dropped or repeated.
module nibble_palette_pixel_effects (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [3:0]                        in_operation,
  input  logic [7:0]                        in_src_pixel,
  input  logic [7:0]                        in_dst_pixel,
  input  logic [7:0]                        in_neighbor_a,
  input  logic [7:0]                        in_neighbor_b,
  input  logic                              in_edge_flag,
  input  logic [8:0]                        in_column,
  input  logic [7:0]                        in_row,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_result_pixel,
  input  logic                              cfg_we,
  input  logic [nppe_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [nppe_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  nppe_pkg::cfg_t  cfg;
  nppe_pkg::prep_t prep_data;
  nppe_pkg::fx_t   fx_data;
  logic            prep_valid;
  logic            fx_valid;
  logic            load_prep;
  logic            load_fx;
  logic            load_sel;

  assign load_sel  = !out_valid || !out_stall;
  assign load_fx   = !fx_valid || load_sel;
  assign load_prep = !prep_valid || load_fx;
  assign in_stall  = !load_prep;

  nppe_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_r     (cfg)
  );

  nppe_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load_prep),
    .valid_in   (in_valid),
    .operation  (in_operation),
    .src_pixel  (in_src_pixel),
    .dst_pixel  (in_dst_pixel),
    .neighbor_a (in_neighbor_a),
    .neighbor_b (in_neighbor_b),
    .edge_flag  (in_edge_flag),
    .column     (in_column),
    .row        (in_row),
    .cfg        (cfg),
    .valid_r    (prep_valid),
    .data_r     (prep_data)
  );

  nppe_fx u_fx (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load_fx),
    .valid_in (prep_valid),
    .data_in  (prep_data),
    .valid_r  (fx_valid),
    .data_r   (fx_data)
  );

  nppe_sel u_sel (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load_sel),
    .valid_in (fx_valid),
    .data_in  (fx_data),
    .cfg      (cfg),
    .valid_r  (out_valid),
    .pixel_r  (out_result_pixel)
  );

endmodule
